### design/tpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared widths and types of the trapezoid pi integrator: field widths, the
// configuration register image and the divider command/status groups.
// ----------------------------------------------------------------------------
package tpi_pkg;

  localparam int VAL_W  = 32;  // fixed-point values
  localparam int CNT_W  = 21;  // interval count
  localparam int WC_W   = 11;  // worker count register
  localparam int WI_W   = 10;  // worker index register
  localparam int ADDR_W = 3;   // APB byte address
  localparam int DATA_W = 32;  // APB data
  localparam int STEP_W = 6;   // divider step counter
  localparam int QUO_W  = 33;  // divider quotient

  typedef struct packed {
    logic [WC_W-1:0] worker_count;
    logic [WI_W-1:0] worker_index;
  } tpi_cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } tpi_div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tpi_div_stat_t;

endpackage
`default_nettype wire

### design/tpi_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpi_regs
// APB configuration registers: worker count (offset 0x0) and worker index
// (offset 0x4). Zero wait states.
// ----------------------------------------------------------------------------
module tpi_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpi_pkg::ADDR_W-1:0]    paddr,
  input  logic [tpi_pkg::DATA_W-1:0]    pwdata,
  output logic [tpi_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output tpi_pkg::tpi_cfg_t             cfg
);
  import tpi_pkg::*;

  typedef enum logic {
    REG_WORKER_COUNT = 1'b0,
    REG_WORKER_INDEX = 1'b1
  } reg_sel_t;

  logic [WC_W-1:0] worker_count_r;
  logic [WI_W-1:0] worker_index_r;
  reg_sel_t        reg_sel;

  assign reg_sel = reg_sel_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= WC_W'(1);
      worker_index_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_WORKER_COUNT: worker_count_r <= pwdata[WC_W-1:0];
        REG_WORKER_INDEX: worker_index_r <= pwdata[WI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WORKER_COUNT: prdata = DATA_W'(worker_count_r);
      REG_WORKER_INDEX: prdata = DATA_W'(worker_index_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.worker_count = worker_count_r;
  assign cfg.worker_index = worker_index_r;

endmodule
`default_nettype wire

### design/tpi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpi_div
// Shared restoring divider, one quotient bit per cycle. The remainder can be
// preloaded so a dividend with known zero low bits needs only the quotient
// bits as steps. Quotient appears in the low 'steps' bits of the result.
// ----------------------------------------------------------------------------
module tpi_div #(
  parameter int DVW = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tpi_pkg::tpi_div_cmd_t       cmd,
  input  logic [DVW-1:0]              rem_init,
  input  logic [tpi_pkg::QUO_W-1:0]   dividend,
  input  logic [DVW-1:0]              divisor,
  output tpi_pkg::tpi_div_stat_t      stat,
  output logic [tpi_pkg::QUO_W-1:0]   quotient
);
  import tpi_pkg::*;

  logic [DVW-1:0]    rem_r;
  logic [QUO_W-1:0]  dvd_r;
  logic [DVW-1:0]    den_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVW:0]      trial;
  logic              fits;
  logic [DVW-1:0]    rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[QUO_W-1]};
    fits    = trial >= {1'b0, den_r};
    // remainder stays below the divisor, so the top bit drops out
    rem_nxt = fits ? DVW'(trial - {1'b0, den_r}) : trial[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (cmd.start) begin
      rem_r  <= rem_init;
      dvd_r  <= dividend;
      den_r  <= divisor;
      cnt_r  <= cmd.steps;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[QUO_W-2:0], fits};
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r)) else $error("divider done without work");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider busy with zero steps left");

endmodule
`default_nettype wire

### design/trapezoid_pi_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_pi_integrator
// One worker's trapezoidal-rule share of the integral of 4/(1+x^2) in
// signed fixed point, built around one shared divider and one multiplier.
// ----------------------------------------------------------------------------
// The time from acceptance to result grows with m, the local trapezoid
// count floor(n/worker_count) clipped to 2^COUNT_BITS, and is set by the
// shared shift-subtract divider, which computes the reciprocal of every
// sample point after dividing up front for the step and local count.
// in_ready is high only between requests, so the next request can be
// taken in the cycle after a result is loaded; a finished result sits in
// the output register so the next request can be taken while it waits.
module trapezoid_pi_integrator #(
  parameter int FRAC_BITS  = 24,
  parameter int COUNT_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tpi_pkg::VAL_W-1:0]  in_lower_bound,
  input  logic signed [tpi_pkg::VAL_W-1:0]  in_upper_bound,
  input  logic [tpi_pkg::CNT_W-1:0]         in_interval_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tpi_pkg::VAL_W-1:0]  out_partial_integral,
  output logic                              out_saturated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpi_pkg::ADDR_W-1:0]        paddr,
  input  logic [tpi_pkg::DATA_W-1:0]        pwdata,
  output logic [tpi_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import tpi_pkg::*;

  localparam int MW  = CNT_W;
  localparam int SW  = MW + VAL_W;
  localparam int SPW = MW + VAL_W + 1;
  localparam int IMW = MW + WI_W;
  localparam int OPW = VAL_W + 1;
  localparam int PW  = 2 * OPW;
  localparam int DVW = 64 - FRAC_BITS;
  localparam int QW  = QUO_W;
  localparam int LW  = 64;

  localparam logic [VAL_W-1:0]     POS_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [OPW-1:0]       NEG_MAG   = OPW'(1) << (VAL_W - 1);
  localparam logic [OPW-1:0]       COUNT_LIM = OPW'(1) << COUNT_BITS;
  localparam logic signed [PW-1:0] WIDE_MAX  = PW'(POS_MAX);
  localparam logic signed [PW-1:0] WIDE_MIN  = ~WIDE_MAX;
  localparam logic [LW-1:0]        Q_OVER    = LW'(1) << VAL_W;

  typedef enum logic [4:0] {
    S_IDLE, S_HDIV, S_HWAIT, S_MDIV, S_MWAIT, S_MUL_IM, S_MUL_SPAN, S_MUL_OFF,
    S_ENDS, S_LB, S_CSQ, S_CDEN, S_CWAIT, S_PLO, S_PHI, S_RES, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_LA, PH_LB, PH_INT
  } phase_t;

  // {clipped flag, value}
  function automatic logic [VAL_W:0] clip_val(input logic signed [PW-1:0] v);
    logic [VAL_W:0] r;
    if (v > WIDE_MAX) begin
      r = {1'b1, POS_MAX};
    end else if (v < WIDE_MIN) begin
      r = {1'b1, ~POS_MAX};
    end else begin
      r = {1'b0, v[VAL_W-1:0]};
    end
    return r;
  endfunction

  tpi_cfg_t      cfg;
  tpi_div_cmd_t  div_cmd;
  tpi_div_stat_t div_stat;
  logic [DVW-1:0] div_rem;
  logic [QW-1:0]  div_dvd;
  logic [DVW-1:0] div_den;
  logic [QW-1:0]  div_quo;

  state_t state_r;
  phase_t phase_r;

  logic signed [VAL_W-1:0] a_r;
  logic [OPW-1:0]          diff_mag_r;
  logic                    diff_neg_r;
  logic [MW-1:0]           n_r;
  logic [WC_W-1:0]         p_r;
  logic signed [VAL_W-1:0] h_r;
  logic [VAL_W-1:0]        hmag_r;
  logic                    hneg_r;
  logic [MW-1:0]           m_r;
  logic [MW-1:0]           i_r;
  logic [IMW-1:0]          im_r;
  logic signed [SPW-1:0]   span_r;
  logic signed [VAL_W-1:0] la_r;
  logic signed [VAL_W-1:0] lb_r;
  logic signed [VAL_W-1:0] cx_r;
  logic [VAL_W-2:0]        fla_r;
  logic [SW-1:0]           sum_r;
  logic [LW-1:0]           plo_r;
  logic [LW-1:0]           q_r;
  logic                    sat_r;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_pi_r;
  logic                    out_sat_r;

  logic signed [OPW-1:0]   mul_a;
  logic signed [OPW-1:0]   mul_b;
  logic signed [PW-1:0]    prod_r;

  logic signed [OPW-1:0]   in_diff;
  logic [VAL_W-1:0]        cmag;
  logic                    h_sat;
  logic [VAL_W-1:0]        h_mag;
  logic [MW-1:0]           m_quo;
  logic                    f_sat;
  logic [VAL_W-2:0]        f_val;
  logic signed [VAL_W-1:0] step_base;
  logic [VAL_W:0]          step_c;
  logic [VAL_W:0]          la_c;
  logic [VAL_W:0]          lb_c;
  logic [LW-1:0]           phi;
  logic                    res_sat;
  logic signed [VAL_W-1:0] res_val;

  tpi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpi_div #(
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // datapath helpers
  always_comb begin
    in_diff   = OPW'(in_upper_bound) - OPW'(in_lower_bound);
    cmag      = cx_r[VAL_W-1] ? (~cx_r + VAL_W'(1)) : cx_r;

    if (diff_neg_r) begin
      h_sat = OPW'(div_quo) > NEG_MAG;
      h_mag = h_sat ? NEG_MAG[VAL_W-1:0] : div_quo[VAL_W-1:0];
    end else begin
      h_sat = div_quo > QW'(POS_MAX);
      h_mag = h_sat ? POS_MAX : div_quo[VAL_W-1:0];
    end

    m_quo     = div_quo[MW-1:0];
    f_sat     = div_quo > QW'(POS_MAX);
    f_val     = f_sat ? POS_MAX[VAL_W-2:0] : div_quo[VAL_W-2:0];

    // next sample point: la+h after the end terms, else previous point + h
    step_base = (phase_r == PH_LB) ? la_r : cx_r;
    step_c    = clip_val(PW'(step_base) + PW'(h_r));
    la_c      = clip_val(PW'(a_r) + prod_r);
    lb_c      = clip_val(PW'(la_r) + PW'(span_r));

    phi       = prod_r[LW-1:0];

    if (hneg_r) begin
      res_sat = q_r > LW'(NEG_MAG);
      res_val = res_sat ? ~POS_MAX : -(q_r[VAL_W-1:0]);
    end else begin
      res_sat = q_r > LW'(POS_MAX);
      res_val = res_sat ? POS_MAX : q_r[VAL_W-1:0];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_IM: begin
        mul_a = $signed(OPW'(cfg.worker_index));
        mul_b = $signed(OPW'(m_r));
      end
      S_MUL_SPAN: begin
        mul_a = $signed(OPW'(m_r));
        mul_b = OPW'(h_r);
      end
      S_MUL_OFF: begin
        mul_a = $signed(OPW'(im_r));
        mul_b = OPW'(h_r);
      end
      S_CSQ: begin
        mul_a = $signed(OPW'(cmag));
        mul_b = $signed(OPW'(cmag));
      end
      S_PLO: begin
        mul_a = $signed(OPW'(sum_r[VAL_W-1:0]));
        mul_b = $signed(OPW'(hmag_r));
      end
      S_PHI: begin
        mul_a = $signed(OPW'(sum_r[SW-1:VAL_W]));
        mul_b = $signed(OPW'(hmag_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // shared divider requests
  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.steps = '0;
    div_rem       = '0;
    div_dvd       = '0;
    div_den       = '0;
    unique case (state_r)
      S_HDIV: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = STEP_W'(QW);
        div_dvd       = diff_mag_r;
        div_den       = DVW'(n_r);
      end
      S_MDIV: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = STEP_W'(MW);
        div_dvd       = {n_r, {(QW-MW){1'b0}}};
        div_den       = DVW'(p_r);
      end
      S_CDEN: begin
        // 4.0 / (1.0 + x^2): dividend 2^(2F+2) as preloaded remainder 2^(F-1)
        div_cmd.start = 1'b1;
        div_cmd.steps = STEP_W'(FRAC_BITS + 3);
        div_rem       = DVW'(1) << (FRAC_BITS - 1);
        div_den       = prod_r[LW-1:FRAC_BITS] + (DVW'(1) << FRAC_BITS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LA;
      out_valid_r <= 1'b0;
    end else begin
      // the finish state reloads the output register on its own
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            a_r        <= in_lower_bound;
            diff_neg_r <= in_diff[VAL_W];
            diff_mag_r <= in_diff[VAL_W] ? OPW'(-in_diff) : OPW'(in_diff);
            n_r        <= (in_interval_count == '0) ? MW'(1) : in_interval_count;
            p_r        <= (cfg.worker_count == '0) ? WC_W'(1) : cfg.worker_count;
            sat_r      <= 1'b0;
            state_r    <= S_HDIV;
          end
        end
        S_HDIV: state_r <= S_HWAIT;
        S_HWAIT: begin
          if (div_stat.done) begin
            h_r     <= diff_neg_r ? -h_mag : h_mag;
            hmag_r  <= h_mag;
            hneg_r  <= diff_neg_r && (div_quo != '0);
            sat_r   <= sat_r | h_sat;
            state_r <= S_MDIV;
          end
        end
        S_MDIV: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (div_stat.done) begin
            if (OPW'(m_quo) > COUNT_LIM) begin
              m_r   <= COUNT_LIM[MW-1:0];
              sat_r <= 1'b1;
            end else begin
              m_r <= m_quo;
            end
            state_r <= S_MUL_IM;
          end
        end
        S_MUL_IM: state_r <= S_MUL_SPAN;
        S_MUL_SPAN: begin
          im_r    <= prod_r[IMW-1:0];
          state_r <= S_MUL_OFF;
        end
        S_MUL_OFF: begin
          span_r  <= prod_r[SPW-1:0];
          state_r <= S_ENDS;
        end
        S_ENDS: begin
          la_r    <= la_c[VAL_W-1:0];
          sat_r   <= sat_r | la_c[VAL_W];
          state_r <= S_LB;
        end
        S_LB: begin
          lb_r    <= lb_c[VAL_W-1:0];
          sat_r   <= sat_r | lb_c[VAL_W];
          cx_r    <= la_r;
          phase_r <= PH_LA;
          state_r <= S_CSQ;
        end
        S_CSQ:  state_r <= S_CDEN;
        S_CDEN: state_r <= S_CWAIT;
        S_CWAIT: begin
          if (div_stat.done) begin
            case (phase_r)
              PH_LA: begin
                fla_r   <= f_val;
                sat_r   <= sat_r | f_sat;
                cx_r    <= lb_r;
                phase_r <= PH_LB;
                state_r <= S_CSQ;
              end
              PH_LB: begin
                sum_r <= (SW'(fla_r) + SW'(f_val)) >> 1;
                if (m_r > MW'(1)) begin
                  sat_r   <= sat_r | f_sat | step_c[VAL_W];
                  cx_r    <= step_c[VAL_W-1:0];
                  i_r     <= MW'(1);
                  phase_r <= PH_INT;
                  state_r <= S_CSQ;
                end else begin
                  sat_r   <= sat_r | f_sat;
                  state_r <= S_PLO;
                end
              end
              default: begin
                sum_r <= sum_r + SW'(f_val);
                if ((i_r + MW'(1)) != m_r) begin
                  sat_r   <= sat_r | f_sat | step_c[VAL_W];
                  cx_r    <= step_c[VAL_W-1:0];
                  i_r     <= i_r + MW'(1);
                  state_r <= S_CSQ;
                end else begin
                  sat_r   <= sat_r | f_sat;
                  state_r <= S_PLO;
                end
              end
            endcase
          end
        end
        S_PLO: state_r <= S_PHI;
        S_PHI: begin
          plo_r   <= prod_r[LW-1:0];
          state_r <= S_RES;
        end
        S_RES: begin
          // high partial product too large: force the result to clip
          if ((phi >> (FRAC_BITS - 1)) != '0) begin
            q_r <= Q_OVER;
          end else begin
            q_r <= (phi << (VAL_W - FRAC_BITS)) + (plo_r >> FRAC_BITS);
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_pi_r    <= res_val;
            out_sat_r   <= sat_r | res_sat;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_partial_integral = out_pi_r;
  assign out_saturated        = out_sat_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_HDIV && !sat_r))
    else $error("request accepted without starting the step division");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result presented outside the finish state");
  a_interior_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CWAIT && phase_r == PH_INT) |-> (i_r != '0 && i_r < m_r))
    else $error("interior point counter out of range");

endmodule
`default_nettype wire
